### rtl/core/b2d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_pkg
// shared types and constants for the binary to decimal digit converter
// ----------------------------------------------------------------------------
package b2d_pkg;

    localparam int DEC_DIGITS = 40;
    localparam int POS_W      = $clog2(DEC_DIGITS);
    localparam int IN_W       = 64;
    localparam int CHAR_W     = 6;

    localparam logic [1:0] ASCII_DIGIT_PREFIX = 2'b11;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic load;
        logic round;
        logic skip;
        logic emit;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic top_zero;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

### rtl/core/b2d_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_datapath
// binary shift register, decimal digit register and output item register
// ----------------------------------------------------------------------------
module b2d_datapath import b2d_pkg::*; #(
    parameter int VALUE_BITS = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [IN_W-1:0]   i_value_low,
    input  wire logic [IN_W-1:0]   i_value_high,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [CHAR_W-1:0]      o_digit_char,
    output logic                   o_last_digit
);

    logic [VALUE_BITS-1:0]  r_bin;
    t_digit                 r_dig [DEC_DIGITS];
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_digit_char;
    logic                   r_last_digit;

    logic [2*IN_W-1:0]      full_value;
    logic [DEC_DIGITS:0]    carry;
    t_digit                 dig_round [DEC_DIGITS];
    logic                   n_out_valid;

    assign full_value = {i_value_high, i_value_low};

    // per-digit double and add, the carry out only depends on the digit itself
    always_comb begin
        carry[DEC_DIGITS] = r_bin[VALUE_BITS-1];
        for (int k = DEC_DIGITS - 1; k >= 0; k--) begin
            logic [3:0] dm;
            dm = (r_dig[k] >= 4'd5) ? (r_dig[k] - 4'd5) : r_dig[k];
            carry[k] = (r_dig[k] >= 4'd5);
            dig_round[k] = {dm[2:0], carry[k+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= full_value[VALUE_BITS-1:0];
            for (int k = 0; k < DEC_DIGITS; k++) begin
                r_dig[k] <= '0;
            end
        end else if (i_cmd.round) begin
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
            for (int k = 0; k < DEC_DIGITS; k++) begin
                r_dig[k] <= dig_round[k];
            end
        end else if (i_cmd.skip || i_cmd.emit) begin
            for (int k = 0; k < DEC_DIGITS - 1; k++) begin
                r_dig[k] <= r_dig[k+1];
            end
            r_dig[DEC_DIGITS-1] <= '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_digit_char <= {ASCII_DIGIT_PREFIX, r_dig[0]};
            r_last_digit <= i_cmd.last;
        end
    end

    assign o_status.top_zero = (r_dig[0] == '0);
    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_digit_char      = r_digit_char;
    assign o_last_digit      = r_last_digit;

endmodule
`default_nettype wire

### rtl/core/b2d_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b2d_controller
// sequences load, conversion rounds and digit emission
// ----------------------------------------------------------------------------
module b2d_controller import b2d_pkg::*; #(
    parameter int VALUE_BITS = 128
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  wire t_status i_status,
    output t_cmd       o_cmd
);

    localparam int RW = $clog2(VALUE_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [RW-1:0]    r_round, n_round;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_started, n_started;
    logic             at_last;

    assign at_last = (r_pos == POS_W'(DEC_DIGITS - 1));

    always_comb begin
        n_state   = r_state;
        n_round   = r_round;
        n_pos     = r_pos;
        n_started = r_started;
        o_cmd     = '0;
        o_cmd.last = at_last;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_round    = RW'(VALUE_BITS - 1);
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.round = 1'b1;
                if (r_round == '0) begin
                    n_pos     = '0;
                    n_started = 1'b0;
                    n_state   = S_EMIT;
                end else begin
                    n_round = r_round - 1'b1;
                end
            end
            S_EMIT: begin
                if (!r_started && i_status.top_zero && !at_last) begin
                    o_cmd.skip = 1'b1;
                    n_pos      = r_pos + 1'b1;
                end else if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_started  = 1'b1;
                    n_pos      = r_pos + 1'b1;
                    if (at_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_round   <= '0;
            r_pos     <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_round   <= n_round;
            r_pos     <= n_pos;
            r_started <= n_started;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

### rtl/core/binary128_to_decimal_digits_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary128_to_decimal_digits_top
// unsigned binary to ascii decimal digits, leading zeros suppressed
// ----------------------------------------------------------------------------
// conversion: one shift-and-double round per bit of the value, then a scan of
// the 40 digit slots, one digit slot per cycle, longer under output stall
// throughput: a new input item is accepted only after the previous one has
// emitted its last digit (o_in_stall is high whenever the sequencer is not idle)
// reset: synchronous, clears the sequencer and the output valid flag
// ----------------------------------------------------------------------------
module binary128_to_decimal_digits_top import b2d_pkg::*; #(
    parameter int VALUE_BITS = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [IN_W-1:0]   i_value_low,
    input  wire logic [IN_W-1:0]   i_value_high,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [CHAR_W-1:0]      o_digit_char,
    output logic                   o_last_digit
);

    t_cmd    cmd;
    t_status status;

    b2d_controller #(
        .VALUE_BITS (VALUE_BITS)
    ) u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    b2d_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value_low  (i_value_low),
        .i_value_high (i_value_high),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule
`default_nettype wire
